FILE: design/spf_pkg.sv
// ----------------------------------------------------------------------------
// spf_pkg: shared types and constants for the scanline span fill unit
// Request and response payload structs, command and status codes.
// ----------------------------------------------------------------------------
package spf_pkg;

   localparam int CoordBits = 10;
   localparam int CountBits = 6;

   typedef enum logic {
      CMD_LOAD = 1'b0,
      CMD_SCAN = 1'b1
   } command_type;

   typedef enum logic [1:0] {
      STATUS_OK     = 2'd0,
      STATUS_FULL   = 2'd1,
      STATUS_OPEN   = 2'd2,
      STATUS_UNUSED = 2'd3
   } status_type;

   typedef struct packed {
      logic                 command;
      logic [CoordBits-1:0] coord_x;
      logic [CoordBits-1:0] coord_y;
      logic                 last_vertex;
   } req_type;

   typedef struct packed {
      logic                 span_valid;
      logic [CoordBits-1:0] span_start;
      logic [CoordBits-1:0] span_end;
      logic                 last_result;
      logic [CountBits-1:0] loaded_count;
      logic [CoordBits-1:0] lowest_y;
      logic [CoordBits-1:0] highest_y;
      logic [1:0]           status;
   } rsp_type;

   typedef struct packed {
      logic start;
      logic done;
   } div_ctl_type;

endpackage

FILE: design/spf_divider.sv
// ----------------------------------------------------------------------------
// spf_divider: shared restoring divider
// Unsigned quotient of num by den, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module spf_divider #(
   parameter int NumBits = 32,
   parameter int DenBits = 12
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [NumBits-1:0]   num,
   input  logic [DenBits-1:0]   den,
   output logic                 done,
   output logic [NumBits-1:0]   quot
);
   localparam int CntBits = $clog2(NumBits + 1);

   logic [NumBits-1:0] quot_ff, quot_in;
   logic [DenBits:0]   rem_ff, rem_in;
   logic [DenBits-1:0] den_ff, den_in;
   logic [CntBits-1:0] cnt_ff, cnt_in;
   logic               busy_ff, busy_in, done_ff, done_in;
   logic [DenBits:0]   trial;
   logic [DenBits+1:0] diff;

   always_comb begin
      quot_in = quot_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff[DenBits-1:0], quot_ff[NumBits-1]};
      diff    = {1'b0, trial} - {2'b00, den_ff};
      if (start) begin
         quot_in = num;
         rem_in  = '0;
         den_in  = den;
         cnt_in  = CntBits'(NumBits);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!diff[DenBits+1]) begin
            rem_in  = diff[DenBits:0];
            quot_in = {quot_ff[NumBits-2:0], 1'b1};
         end else begin
            rem_in  = trial;
            quot_in = {quot_ff[NumBits-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CntBits'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      cnt_ff  <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign quot = quot_ff;

   assert property (@(posedge clock) disable iff (reset) done |-> !busy_ff)
      else $error("divider done while busy");
   assert property (@(posedge clock) disable iff (reset) start |=> busy_ff)
      else $error("divider did not start");
   assert property (@(posedge clock) disable iff (reset) busy_ff |-> cnt_ff != '0)
      else $error("divider count underflow");
endmodule

FILE: design/scanline_polygon_span_fill_unit.sv
// ----------------------------------------------------------------------------
// scanline_polygon_span_fill_unit: even-odd scanline span generator
// Holds one polygon and returns the filled spans of a requested row.
// ----------------------------------------------------------------------------
// Usage: drive req_payload and pulse start while busy is low. A load request
// (command 0) stores one vertex; last_vertex closes the polygon, and the next
// load starts a new one. A scan request (command 1) returns the spans of row
// coord_y, one per rsp_strobe cycle, last_result on the final one; a scan
// with no span, an open polygon, or any load returns a single response.
// Sequence: a load is answered from ST_DONE. A scan walks the edges one at
// a time, each through ST_EDGE_RD, ST_EDGE_RD2, ST_EDGE and ST_DIV, and an
// edge that crosses the row also through ST_MUL and the shared bit-serial
// divider of 2*COORD_BITS+2 steps; then an insertion sort over the crossing
// memory, one compare per cycle; then ST_EMIT_RD, ST_EMIT and ST_EMIT2 for
// each span.
// busy is high from acceptance until the last response is shown.
// Reset clears the vertex count, closed flag and y range; the vertex memories
// need no clearing. The receiver cannot stall: each response is valid for
// exactly one cycle.
// ----------------------------------------------------------------------------
module scanline_polygon_span_fill_unit #(
   parameter int MAX_VERTICES = 32,
   parameter int COORD_BITS   = 10
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  spf_pkg::req_type  req_payload,
   output logic              rsp_strobe,
   output spf_pkg::rsp_type  rsp_payload
);
   import spf_pkg::*;

   localparam int AddrBits = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
   localparam int TotBits  = $clog2(MAX_VERTICES + 1);
   localparam int CB       = COORD_BITS;
   localparam int NumBits  = 2 * CB + 2;
   localparam int DenBits  = CB + 2;
   localparam int SpanLimit = 16;
   localparam logic [CB-1:0] CoordMax = {CB{1'b1}};

   typedef enum logic [3:0] {
      ST_IDLE, ST_EDGE_RD, ST_EDGE_RD2, ST_EDGE, ST_MUL, ST_DIV, ST_SORT_RD, ST_SORT,
      ST_EMIT_RD, ST_EMIT, ST_EMIT2, ST_DONE
   } state_type;

   state_type          state_ff;
   logic [CB-1:0]      vx_mem [MAX_VERTICES];
   logic [CB-1:0]      vy_mem [MAX_VERTICES];
   logic [CB-1:0]      xb_mem [MAX_VERTICES];
   logic [TotBits-1:0] total_ff;
   logic               closed_ff;
   logic [CB-1:0]      ymin_ff, ymax_ff, row_ff;
   logic [TotBits-1:0] edge_ff, cnt_ff, si_ff, sk_ff, span_ff, nspan_ff;
   logic [CB-1:0]      xi_ff, yi_ff, xj_ff, yj_ff, sv_ff, rd_ff, lo_ff;
   logic               neg_ff;
   logic [NumBits-1:0] num_ff;
   logic [DenBits-1:0] den_ff;
   logic               div_start;
   logic               div_done;
   logic [NumBits-1:0] div_q;
   logic               rsp_strobe_ff;
   rsp_type            rsp_ff;
   logic [CB:0]        adx, ady, ddy;
   logic               cross_hit;
   logic [CB+1:0]      xsum;
   logic [TotBits-1:0] nxt_edge;

   spf_divider #(.NumBits(NumBits), .DenBits(DenBits)) u_div (
      .clock(clock), .reset(reset), .start(div_start),
      .num(num_ff), .den(den_ff), .done(div_done), .quot(div_q)
   );

   assign nxt_edge  = (edge_ff + 1'b1 == total_ff) ? '0 : edge_ff + 1'b1;
   assign cross_hit = (row_ff >= yi_ff && row_ff < yj_ff) ||
                      (row_ff < yi_ff && row_ff >= yj_ff);
   assign adx = (xj_ff >= xi_ff) ? {1'b0, xj_ff - xi_ff} : {1'b0, xi_ff - xj_ff};
   assign ady = (yj_ff >= yi_ff) ? {1'b0, yj_ff - yi_ff} : {1'b0, yi_ff - yj_ff};
   assign ddy = (row_ff >= yi_ff) ? {1'b0, row_ff - yi_ff} : {1'b0, yi_ff - row_ff};
   assign xsum = neg_ff ? ({2'b00, xi_ff} - (CB+2)'(div_q))
                        : ({2'b00, xi_ff} + (CB+2)'(div_q));
   assign div_start = (state_ff == ST_MUL);

   function automatic rsp_type mk_rsp(logic v, logic [CB-1:0] s, logic [CB-1:0] e,
                                      logic l, logic [1:0] st,
                                      logic [TotBits-1:0] tot,
                                      logic [CB-1:0] lo, logic [CB-1:0] hi);
      rsp_type r;
      r.span_valid   = v;
      r.span_start   = CoordBits'(s);
      r.span_end     = CoordBits'(e);
      r.last_result  = l;
      r.loaded_count = (TotBits > CountBits && tot > TotBits'(63)) ? 6'd63
                       : CountBits'(tot);
      r.lowest_y     = CoordBits'(lo);
      r.highest_y    = CoordBits'(hi);
      r.status       = st;
      return r;
   endfunction

   always_ff @(posedge clock) begin
      if (start && !busy && req_payload.command == CMD_LOAD) begin
         if (!(closed_ff == 1'b0 && total_ff >= TotBits'(MAX_VERTICES))) begin
            vx_mem[closed_ff ? '0 : AddrBits'(total_ff)] <= CB'(req_payload.coord_x);
            vy_mem[closed_ff ? '0 : AddrBits'(total_ff)] <= CB'(req_payload.coord_y);
         end
      end
      if (state_ff == ST_EDGE_RD || state_ff == ST_EDGE_RD2) begin
         xi_ff <= xj_ff;
         yi_ff <= yj_ff;
         xj_ff <= vx_mem[AddrBits'(state_ff == ST_EDGE_RD ? edge_ff : nxt_edge)];
         yj_ff <= vy_mem[AddrBits'(state_ff == ST_EDGE_RD ? edge_ff : nxt_edge)];
      end
      if (state_ff == ST_EDGE) begin
         num_ff <= NumBits'(({1'b0, ddy} * {1'b0, adx}) * 2) + NumBits'(ady);
         den_ff <= DenBits'({ady, 1'b0});
         neg_ff <= (xj_ff < xi_ff) && adx != '0 && ddy != '0;
      end
      if (state_ff == ST_DIV && div_done) begin
         xb_mem[AddrBits'(cnt_ff)] <= xsum[CB+1] ? '0 :
                                      (xsum[CB] ? CoordMax : xsum[CB-1:0]);
      end
      rd_ff <= xb_mem[AddrBits'(state_ff == ST_EMIT_RD ? {span_ff, 1'b0} :
                               (state_ff == ST_EMIT ? {span_ff, 1'b1} :
                               (state_ff == ST_SORT_RD ? si_ff - 1'b1 : sk_ff - 2'd2)))];
      if (state_ff == ST_SORT_RD) sv_ff <= xb_mem[AddrBits'(si_ff)];
      if (state_ff == ST_SORT) begin
         if (sk_ff != '0 && rd_ff > sv_ff) xb_mem[AddrBits'(sk_ff)] <= rd_ff;
         else xb_mem[AddrBits'(sk_ff)] <= sv_ff;
      end
      if (state_ff == ST_EMIT) lo_ff <= rd_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         total_ff      <= '0;
         closed_ff     <= 1'b0;
         ymin_ff       <= CoordMax;
         ymax_ff       <= '0;
         rsp_strobe_ff <= 1'b0;
         edge_ff       <= '0;
         cnt_ff        <= '0;
         si_ff         <= '0;
         sk_ff         <= '0;
         span_ff       <= '0;
         nspan_ff      <= '0;
         row_ff        <= '0;
      end else begin
         rsp_strobe_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               if (start) begin
                  if (req_payload.command == CMD_LOAD) begin
                     logic [TotBits-1:0] t;
                     logic [CB-1:0] lo, hi, cy;
                     logic [1:0] st;
                     t  = closed_ff ? '0 : total_ff;
                     lo = closed_ff ? CoordMax : ymin_ff;
                     hi = closed_ff ? '0 : ymax_ff;
                     cy = CB'(req_payload.coord_y);
                     st = STATUS_OK;
                     if (t >= TotBits'(MAX_VERTICES)) st = STATUS_FULL;
                     else begin
                        t = t + 1'b1;
                        if (cy < lo) lo = cy;
                        if (cy > hi) hi = cy;
                     end
                     total_ff  <= t;
                     ymin_ff   <= lo;
                     ymax_ff   <= hi;
                     closed_ff <= req_payload.last_vertex;
                     rsp_ff    <= mk_rsp(1'b0, '0, '0, 1'b1, st, t, lo, hi);
                     state_ff  <= ST_DONE;
                  end else if (!closed_ff || total_ff == '0) begin
                     rsp_ff   <= mk_rsp(1'b0, '0, '0, 1'b1, STATUS_OPEN, total_ff,
                                        ymin_ff, ymax_ff);
                     state_ff <= ST_DONE;
                  end else begin
                     row_ff   <= CB'(req_payload.coord_y);
                     edge_ff  <= '0;
                     cnt_ff   <= '0;
                     state_ff <= ST_EDGE_RD;
                  end
               end
            end
            ST_EDGE_RD:  state_ff <= ST_EDGE_RD2;
            ST_EDGE_RD2: state_ff <= ST_EDGE;
            ST_EDGE: state_ff <= cross_hit ? ST_MUL : ST_DIV;
            ST_MUL:  state_ff <= ST_DIV;
            ST_DIV: begin
               if (!cross_hit || div_done) begin
                  if (cross_hit) cnt_ff <= cnt_ff + 1'b1;
                  if (edge_ff + 1'b1 == total_ff) begin
                     si_ff    <= TotBits'(1);
                     state_ff <= ST_SORT_RD;
                  end else begin
                     edge_ff  <= edge_ff + 1'b1;
                     state_ff <= ST_EDGE_RD;
                  end
               end
            end
            ST_SORT_RD: begin
               if (si_ff >= cnt_ff) begin
                  span_ff  <= '0;
                  nspan_ff <= ((cnt_ff >> 1) > TotBits'(SpanLimit)) ? TotBits'(SpanLimit)
                                                                    : (cnt_ff >> 1);
                  state_ff <= ST_EMIT_RD;
               end else begin
                  sk_ff    <= si_ff;
                  state_ff <= ST_SORT;
               end
            end
            ST_SORT: begin
               if (sk_ff != '0 && rd_ff > sv_ff) sk_ff <= sk_ff - 1'b1;
               else begin
                  si_ff    <= si_ff + 1'b1;
                  state_ff <= ST_SORT_RD;
               end
            end
            ST_EMIT_RD: begin
               if (nspan_ff == '0) begin
                  rsp_ff   <= mk_rsp(1'b0, '0, '0, 1'b1, STATUS_OK, total_ff,
                                     ymin_ff, ymax_ff);
                  state_ff <= ST_DONE;
               end else state_ff <= ST_EMIT;
            end
            ST_EMIT:  state_ff <= ST_EMIT2;
            ST_EMIT2: begin
               rsp_strobe_ff <= 1'b1;
               rsp_ff <= mk_rsp(1'b1, lo_ff, rd_ff, span_ff + 1'b1 == nspan_ff,
                                STATUS_OK, total_ff, ymin_ff, ymax_ff);
               span_ff  <= span_ff + 1'b1;
               state_ff <= (span_ff + 1'b1 == nspan_ff) ? ST_IDLE : ST_EMIT_RD;
            end
            ST_DONE: begin
               rsp_strobe_ff <= 1'b1;
               state_ff      <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign busy        = (state_ff != ST_IDLE);
   assign rsp_strobe  = rsp_strobe_ff;
   assign rsp_payload = rsp_ff;

   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("request accepted but unit not busy");
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_payload.span_valid |-> rsp_payload.span_start <= rsp_payload.span_end)
      else $error("span out of order");
   assert property (@(posedge clock) disable iff (reset)
      total_ff <= TotBits'(MAX_VERTICES))
      else $error("vertex count overflow");
   assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE && state_ff != ST_DONE) |-> cnt_ff <= total_ff)
      else $error("more crossings than edges");
endmodule

FILE: tb/sv/scanline_polygon_span_fill_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// scanline_polygon_span_fill_unit_tb: self-checking bench for the span filler
// Loads polygons vertex by vertex and scans rows. A directed table covers the
// reset state, open scans, horizontal edges and coordinate extremes; a store
// overflow run and random polygons with random rows follow. Every response is
// compared field by field with a behavioral span predictor.
// ----------------------------------------------------------------------------
module scanline_polygon_span_fill_unit_tb;
   import spf_pkg::*;

   localparam int MaxVerts  = 32;
   localparam int CoordMax  = 1023;
   localparam int SpanMax   = 16;
   localparam int StallLimit = 20000;

   typedef struct {
      req_type req;
      bit      has_expect;
      rsp_type expect_rsp;
   } stim_row_type;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_payload;
   logic    rsp_strobe;
   rsp_type rsp_payload;

   int          poly_xs [MaxVerts];
   int          poly_ys [MaxVerts];
   int          poly_count;
   bit          poly_closed;
   int          poly_min_y;
   int          poly_max_y;
   rsp_type     span_queue [$];
   stim_row_type stim_rows [$];
   int          error_count;
   int          idle_cycles;
   bit          quiet_phase;

   scanline_polygon_span_fill_unit dut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_payload (req_payload),
      .rsp_strobe  (rsp_strobe),
      .rsp_payload (rsp_payload)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   function automatic rsp_type make_rsp(bit valid, int s, int e, bit last, int status);
      rsp_type r;
      r.span_valid   = valid;
      r.span_start   = s[CoordBits-1:0];
      r.span_end     = e[CoordBits-1:0];
      r.last_result  = last;
      r.loaded_count = poly_count[CountBits-1:0];
      r.lowest_y     = poly_min_y[CoordBits-1:0];
      r.highest_y    = poly_max_y[CoordBits-1:0];
      r.status       = status[1:0];
      return r;
   endfunction

   function automatic int crossing_x(int x0, longint num, longint den);
      bit     neg;
      longint an;
      longint ad;
      longint q;
      longint x;
      neg = (num < 0) != (den < 0);
      an  = num < 0 ? -num : num;
      ad  = den < 0 ? -den : den;
      q   = (2 * an + ad) / (2 * ad);
      x   = x0 + (neg ? -q : q);
      if (x < 0) x = 0;
      if (x > CoordMax) x = CoordMax;
      return int'(x);
   endfunction

   task automatic predict_spans(req_type req);
      int xs [$];
      int j;
      int y;
      int n;
      status_type st;
      if (req.command == CMD_LOAD) begin
         st = STATUS_OK;
         if (poly_closed) begin
            poly_count  = 0;
            poly_closed = 0;
            poly_min_y  = CoordMax;
            poly_max_y  = 0;
         end
         if (poly_count >= MaxVerts) begin
            st = STATUS_FULL;
         end else begin
            poly_xs[poly_count] = req.coord_x;
            poly_ys[poly_count] = req.coord_y;
            poly_count++;
            if (req.coord_y < poly_min_y) poly_min_y = req.coord_y;
            if (req.coord_y > poly_max_y) poly_max_y = req.coord_y;
         end
         if (req.last_vertex) poly_closed = 1;
         span_queue.push_back(make_rsp(0, 0, 0, 1, st));
      end else if (!poly_closed || poly_count == 0) begin
         span_queue.push_back(make_rsp(0, 0, 0, 1, STATUS_OPEN));
      end else begin
         y = req.coord_y;
         for (int i = 0; i < poly_count; i++) begin
            j = (i + 1 == poly_count) ? 0 : i + 1;
            if ((y >= poly_ys[i] && y < poly_ys[j]) || (y < poly_ys[i] && y >= poly_ys[j]))
               xs.push_back(crossing_x(poly_xs[i],
                  longint'(y - poly_ys[i]) * (poly_xs[j] - poly_xs[i]),
                  poly_ys[j] - poly_ys[i]));
         end
         xs.sort();
         n = xs.size() / 2;
         if (n > SpanMax) n = SpanMax;
         if (n == 0)
            span_queue.push_back(make_rsp(0, 0, 0, 1, STATUS_OK));
         for (int s = 0; s < n; s++)
            span_queue.push_back(make_rsp(1, xs[2*s], xs[2*s+1], s + 1 == n, STATUS_OK));
      end
   endtask

   function automatic req_type make_req(command_type cmd, int x, int y, bit lastv);
      req_type r;
      r.command     = cmd;
      r.coord_x     = x[CoordBits-1:0];
      r.coord_y     = y[CoordBits-1:0];
      r.last_vertex = lastv;
      return r;
   endfunction

   task automatic add_row(command_type cmd, int x, int y, bit lastv);
      stim_row_type row;
      row.req        = make_req(cmd, x, y, lastv);
      row.has_expect = 0;
      stim_rows.push_back(row);
   endtask

   task automatic add_checked_row(command_type cmd, int x, int y, bit lastv, rsp_type r);
      stim_row_type row;
      row.req        = make_req(cmd, x, y, lastv);
      row.has_expect = 1;
      row.expect_rsp = r;
      stim_rows.push_back(row);
   endtask

   function automatic rsp_type fixed_rsp(int cnt, int lo, int hi, int status);
      rsp_type r;
      r = '0;
      r.last_result  = 1;
      r.loaded_count = cnt[CountBits-1:0];
      r.lowest_y     = lo[CoordBits-1:0];
      r.highest_y    = hi[CoordBits-1:0];
      r.status       = status[1:0];
      return r;
   endfunction

   task automatic send_request(req_type req, bit may_idle);
      int gap;
      if (may_idle && !quiet_phase && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 14);
         repeat (gap) @(negedge clock);
      end
      while (busy) @(negedge clock);
      req_payload <= req;
      start       <= 1'b1;
      @(posedge clock);
      predict_spans(req);
      @(negedge clock);
      start <= 1'b0;
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (span_queue.size() == 0) begin
            $display("%0t: unexpected response %p", $time, rsp_payload);
            error_count++;
         end else begin
            if (rsp_payload !== span_queue[0])
               $display("%0t: mismatch expected %p actual %p", $time, span_queue[0],
                        rsp_payload);
            if (rsp_payload !== span_queue[0]) error_count++;
            void'(span_queue.pop_front());
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > StallLimit) begin
         $display("tb: failure");
         $finish;
      end
   end

   task automatic random_polygon(int nverts, int spread);
      int cx;
      int cy;
      cx = $urandom_range(0, CoordMax);
      cy = $urandom_range(0, CoordMax);
      for (int i = 0; i < nverts; i++)
         send_request(make_req(CMD_LOAD,
            cx + $urandom_range(0, 2 * spread) - spread > CoordMax ? CoordMax :
            (cx + int'($urandom_range(0, 2 * spread)) - spread < 0 ? 0 :
             cx + int'($urandom_range(0, 2 * spread)) - spread),
            $urandom_range(0, CoordMax), i == nverts - 1), 1);
   endtask

   initial begin
      int nv;
      int lo;
      int hi;
      int sent;
      reset       = 1'b1;
      start       = 1'b0;
      req_payload = '0;
      error_count = 0;
      idle_cycles = 0;
      quiet_phase = 0;
      poly_count  = 0;
      poly_closed = 0;
      poly_min_y  = CoordMax;
      poly_max_y  = 0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: open scan, extremes, horizontal edge, triangle
      add_checked_row(CMD_SCAN, 0, 0, 0, fixed_rsp(0, CoordMax, 0, STATUS_OPEN));
      add_checked_row(CMD_LOAD, 0, 0, 0, fixed_rsp(1, 0, 0, STATUS_OK));
      add_checked_row(CMD_LOAD, CoordMax, CoordMax, 1,
                      fixed_rsp(2, 0, CoordMax, STATUS_OK));
      add_row(CMD_SCAN, CoordMax, 500, 0);
      add_checked_row(CMD_LOAD, 100, 100, 0, fixed_rsp(1, 100, 100, STATUS_OK));
      add_row(CMD_LOAD, 900, 100, 0);
      add_row(CMD_LOAD, 500, 900, 1);
      add_row(CMD_SCAN, 0, 100, 0);
      add_row(CMD_SCAN, 0, 101, 0);
      add_row(CMD_SCAN, 0, 899, 0);
      add_row(CMD_SCAN, 0, 900, 0);
      add_row(CMD_SCAN, 0, 0, 0);
      add_row(CMD_LOAD, 0, 0, 0);
      add_row(CMD_LOAD, 1, 3, 0);
      add_row(CMD_LOAD, CoordMax, 2, 1);
      add_row(CMD_SCAN, 0, 1, 0);
      add_row(CMD_SCAN, 0, 2, 0);
      foreach (stim_rows[i]) begin
         send_request(stim_rows[i].req, 1);
         if (stim_rows[i].has_expect && span_queue.size() > 0)
            span_queue[span_queue.size() - 1] = stim_rows[i].expect_rsp;
      end

      // overflow: 32 vertices then one dropped closing vertex
      for (int i = 0; i < MaxVerts; i++)
         send_request(make_req(CMD_LOAD, (i * 97) % 1024, (i * 311) % 1024, 0), 1);
      send_request(make_req(CMD_LOAD, 5, 5, 1), 1);
      send_request(make_req(CMD_SCAN, 0, 512, 0), 1);
      send_request(make_req(CMD_SCAN, 0, 311, 0), 1);

      sent = 0;
      while (sent < 500) begin
         if (sent > 420) quiet_phase = 1;
         if ($urandom_range(0, 9) == 0) begin
            send_request(make_req(command_type'($urandom_range(0, 1)),
               $urandom_range(0, CoordMax), $urandom_range(0, CoordMax),
               $urandom_range(0, 1)), 1);
            sent++;
         end else begin
            nv = $urandom_range(0, 7) == 0 ? $urandom_range(1, 34) : $urandom_range(3, 8);
            random_polygon(nv, $urandom_range(0, 1) ? CoordMax : 200);
            sent += nv;
            lo = poly_min_y;
            hi = poly_max_y;
            repeat ($urandom_range(2, 6)) begin
               send_request(make_req(CMD_SCAN, $urandom_range(0, CoordMax),
                  $urandom_range(0, 3) == 0 ? $urandom_range(0, CoordMax) :
                  $urandom_range(lo, hi), 0), 1);
               sent++;
            end
         end
      end

      while (busy || span_queue.size() > 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (error_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
